// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/bc7bd_pkg.sv -----
// Types, partition tables and weight tables for the BC7 block decoder.
// No dependencies; imported by the front, queue and back modules.
`timescale 1ns / 1ps

package bc7bd_pkg;

  typedef enum logic [1:0] {
    MODE_UNSUP,
    MODE_1,
    MODE_6,
    MODE_7
  } mode_t;

  // One classified block as handed from the front to the back
  typedef struct packed {
    mode_t                      mode;
    logic                       two_sub;
    logic [15:0]                part_mask;
    logic [3:0]                 anchor;
    logic [1:0][1:0][3:0][7:0]  ends;     // [subset][endpoint][channel]
    logic [63:0]                idx_bits;
  } desc_t;

  localparam logic [15:0] PART_MASK [64] = '{
    16'hCCCC, 16'h8888, 16'hEEEE, 16'hECC8, 16'hC880, 16'hFEEC, 16'hFEC8, 16'hEC80,
    16'hC800, 16'hFFEC, 16'hFE80, 16'hE800, 16'hFFE8, 16'hFF00, 16'hFFF0, 16'hF000,
    16'hF710, 16'h008E, 16'h7100, 16'h08CE, 16'h008C, 16'h7310, 16'h3100, 16'h8CCE,
    16'h088C, 16'h3110, 16'h6666, 16'h366C, 16'h17E8, 16'h0FF0, 16'h718E, 16'h399C,
    16'hAAAA, 16'hF0F0, 16'h5A5A, 16'h33CC, 16'h3C3C, 16'h55AA, 16'h9696, 16'hA55A,
    16'h73CE, 16'h13C8, 16'h324C, 16'h3BDC, 16'h6996, 16'hC33C, 16'h9966, 16'h0660,
    16'h0272, 16'h04E4, 16'h4E40, 16'h2720, 16'hC936, 16'h936C, 16'h39C6, 16'h639C,
    16'h9336, 16'h9CC6, 16'h817E, 16'hE718, 16'hCCF0, 16'h0FCC, 16'h7744, 16'hEE22
  };

  localparam logic [3:0] PART_ANCHOR [64] = '{
    4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15,
    4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15,
    4'd15, 4'd2,  4'd8,  4'd2,  4'd2,  4'd8,  4'd8,  4'd15,
    4'd2,  4'd8,  4'd2,  4'd2,  4'd8,  4'd8,  4'd2,  4'd2,
    4'd15, 4'd15, 4'd6,  4'd8,  4'd2,  4'd8,  4'd15, 4'd15,
    4'd2,  4'd8,  4'd2,  4'd2,  4'd2,  4'd15, 4'd15, 4'd6,
    4'd6,  4'd2,  4'd6,  4'd8,  4'd15, 4'd15, 4'd2,  4'd2,
    4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd2,  4'd2,  4'd15
  };

  localparam logic [6:0] WT2 [4]  = '{7'd0, 7'd21, 7'd43, 7'd64};
  localparam logic [6:0] WT3 [8]  = '{7'd0, 7'd9, 7'd18, 7'd27, 7'd37, 7'd46, 7'd55, 7'd64};
  localparam logic [6:0] WT4 [16] = '{7'd0, 7'd4, 7'd9, 7'd13, 7'd17, 7'd21, 7'd26, 7'd30,
                                      7'd34, 7'd38, 7'd43, 7'd47, 7'd51, 7'd55, 7'd60, 7'd64};

  // Index width of a normal texel in each mode
  function automatic logic [2:0] index_bits(input mode_t m);
    logic [2:0] r;
    unique case (m)
      MODE_1:  r = 3'd3;
      MODE_6:  r = 3'd4;
      MODE_7:  r = 3'd2;
      default: r = 3'd2;
    endcase
    return r;
  endfunction

  // Interpolation weight of an index
  function automatic logic [6:0] weight(input mode_t m, input logic [3:0] idx);
    logic [6:0] r;
    unique case (m)
      MODE_1:  r = WT3[idx[2:0]];
      MODE_6:  r = WT4[idx];
      MODE_7:  r = WT2[idx[1:0]];
      default: r = 7'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/bc7bd_front.sv -----
// Front end: reads the mode of a block, unpacks partition, endpoints and p-bits.
// Depends on bc7bd_pkg.
`timescale 1ns / 1ps

module bc7bd_front import bc7bd_pkg::*; (
  input  logic [63:0] block_low,
  input  logic [63:0] block_high,
  output desc_t       desc
);

  logic [127:0] blk;
  logic [5:0]   part;
  logic [6:0]   x7;
  logic [5:0]   x6;
  logic [6:0]   c7;

  assign blk = {block_high, block_low};

  // Classify the block and expand its endpoints to eight bits, by bit replication in modes 1 and 7
  always_comb begin
    desc = '0;
    part = 6'd0;
    x7   = 7'd0;
    x6   = 6'd0;
    c7   = 7'd0;
    if (blk[1:0] == 2'b10) begin
      desc.mode    = MODE_1;
      desc.two_sub = 1'b1;
      part         = blk[7:2];
      desc.idx_bits = {18'd0, blk[127:82]};
      for (int s = 0; s < 2; s++) begin
        for (int e = 0; e < 2; e++) begin
          for (int c = 0; c < 3; c++) begin
            x7 = {blk[8 + ((c * 2 + s) * 2 + e) * 6 +: 6], blk[80 + s]};
            desc.ends[s][e][c] = {x7, x7[6]};
          end
          desc.ends[s][e][3] = 8'hFF;
        end
      end
    end else if (blk[6:0] == 7'b1000000) begin
      desc.mode     = MODE_6;
      desc.idx_bits = {1'b0, blk[127:65]};
      for (int e = 0; e < 2; e++) begin
        for (int c = 0; c < 3; c++) begin
          c7 = blk[7 + (c * 2 + e) * 7 +: 7];
          desc.ends[0][e][c] = {c7, blk[63 + e]};
        end
        c7 = blk[49 + e * 7 +: 7];
        desc.ends[0][e][3] = {c7, blk[63 + e]};
      end
    end else if (blk[7:0] == 8'h80) begin
      desc.mode     = MODE_7;
      desc.two_sub  = 1'b1;
      part          = blk[13:8];
      desc.idx_bits = {34'd0, blk[127:98]};
      for (int s = 0; s < 2; s++) begin
        for (int e = 0; e < 2; e++) begin
          for (int c = 0; c < 3; c++) begin
            x6 = {blk[14 + ((c * 2 + s) * 2 + e) * 5 +: 5], blk[94 + s * 2 + e]};
            desc.ends[s][e][c] = {x6, x6[5:4]};
          end
          x6 = {blk[74 + (s * 2 + e) * 5 +: 5], blk[94 + s * 2 + e]};
          desc.ends[s][e][3] = {x6, x6[5:4]};
        end
      end
    end
    desc.part_mask = PART_MASK[part];
    desc.anchor    = PART_ANCHOR[part];
  end

endmodule

// ----- rtl/bc7bd_queue.sv -----
// Short queue of classified blocks between the front and the back end.
// Depends on bc7bd_pkg.
`timescale 1ns / 1ps

module bc7bd_queue import bc7bd_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  desc_t wr_data,
  input  logic  rd_en,
  output desc_t rd_data,
  output logic  full,
  output logic  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  desc_t           mem_r [DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= (wp_r == LAST) ? '0 : wp_r + 1'b1;
      end
      if (rd_en) begin
        rp_r <= (rp_r == LAST) ? '0 : rp_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/bc7bd_back.sv -----
// Back end: walks the 16 texels of a queued block, picks weights and blends.
// Depends on bc7bd_pkg.
`timescale 1ns / 1ps

module bc7bd_back import bc7bd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  desc_t       head,
  input  logic        head_empty,
  output logic        head_pop,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [3:0]  out_texel_number,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha_out,
  output logic        out_status,
  output logic        out_last_texel
);

  logic              adv;
  logic              fire;
  logic [3:0]        t_r;
  logic [63:0]       sr_r;
  logic [63:0]       cur;
  logic              is_anchor;
  logic [2:0]        cnt;
  logic [3:0]        idx;
  logic              sub;

  logic              s1_v_r;
  logic [3:0]        s1_t_r;
  logic [6:0]        s1_w_r;
  logic [3:0][7:0]   s1_e0_r, s1_e1_r;
  logic              s1_unsup_r;

  logic              out_v_r;
  logic [3:0][7:0]   blend_val;
  logic [3:0][7:0]   out_ch_r;
  logic [3:0]        out_t_r;
  logic              out_unsup_r;

  // Whole pipeline moves when the output register is free or being drained
  assign adv      = !out_v_r || out_pop;
  assign fire     = adv && !head_empty;
  assign head_pop = fire && (t_r == 4'd15);

  // Pick this texel's index bits
  always_comb begin
    cur       = (t_r == 4'd0) ? head.idx_bits : sr_r;
    is_anchor = (t_r == 4'd0) || (head.two_sub && (t_r == head.anchor));
    cnt       = index_bits(head.mode) - {2'b00, is_anchor};
    idx       = cur[3:0] & ~(4'hF << cnt);
    sub       = head.two_sub & head.part_mask[t_r];
  end

  // Advance the texel counter and index shifter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r <= 4'd0;
    end else if (fire) begin
      t_r <= t_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      sr_r <= cur >> cnt;
    end
  end

  // Stage 1: weight and endpoints of the texel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_t_r     <= t_r;
      s1_w_r     <= weight(head.mode, idx);
      s1_e0_r    <= head.ends[sub][0];
      s1_e1_r    <= head.ends[sub][1];
      s1_unsup_r <= (head.mode == MODE_UNSUP);
    end
  end

  // Blend each channel
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      blend_val[c] = 8'((15'(7'd64 - s1_w_r) * 15'(s1_e0_r[c])
                       + 15'(s1_w_r) * 15'(s1_e1_r[c]) + 15'd32) >> 6);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch_r    <= blend_val;
      out_t_r     <= s1_t_r;
      out_unsup_r <= s1_unsup_r;
    end
  end

  assign out_empty        = !out_v_r;
  assign out_texel_number = out_t_r;
  assign out_red          = out_ch_r[0];
  assign out_green        = out_ch_r[1];
  assign out_blue         = out_ch_r[2];
  assign out_alpha_out    = out_ch_r[3];
  assign out_status       = out_unsup_r;
  assign out_last_texel   = (out_t_r == 4'd15);

endmodule

// ----- rtl/bc7_block_decoder_unit.sv -----
// BC7 block decoder for modes 1, 6 and 7: takes one 128-bit block per push and
// delivers 16 RGBA8 texels in raster order, one per cycle while out_pop is held.
// A block is classified in the cycle it is pushed and waits in a QUEUE_DEPTH-deep
// queue; its texels then pass the back end's stage 1 and output registers. Other
// modes give 16 zero texels with status set. Depends on bc7bd_pkg, bc7bd_front,
// bc7bd_queue, bc7bd_back.
`timescale 1ns / 1ps

module bc7_block_decoder_unit import bc7bd_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [63:0] in_block_low,
  input  logic [63:0] in_block_high,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [3:0]  out_texel_number,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha_out,
  output logic        out_status,
  output logic        out_last_texel
);

  desc_t front_desc;
  desc_t head;
  logic  q_full, q_empty, q_pop;

  assign in_full = q_full;

  // Classify the incoming block
  bc7bd_front u_front (
    .block_low  (in_block_low),
    .block_high (in_block_high),
    .desc       (front_desc)
  );

  // Hold classified blocks
  bc7bd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_push && !q_full),
    .wr_data (front_desc),
    .rd_en   (q_pop),
    .rd_data (head),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Produce texels
  bc7bd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .head_empty       (q_empty),
    .head_pop         (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_texel_number (out_texel_number),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha_out    (out_alpha_out),
    .out_status       (out_status),
    .out_last_texel   (out_last_texel)
  );

endmodule

// ----- rtl/bc7bd_checker.sv -----
// Port-level checks for the BC7 block decoder, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bc7bd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_empty,
  input logic       out_pop,
  input logic [3:0] out_texel_number,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [7:0] out_alpha_out,
  input logic       out_status,
  input logic       out_last_texel
);

  // Nothing to show right after reset
  `ASSERT_ALWAYS(a_empty_after_reset, clk, !rst_n |=> out_empty, "texel shown after reset")

  // Texels of a block come in order
  `ASSERT_CLK(a_texel_order, clk, rst_n, (!out_empty && out_pop && !out_last_texel) ##1 !out_empty |-> out_texel_number == $past(out_texel_number) + 4'd1, "texel out of order")

  // Last flag marks texel fifteen
  `ASSERT_CLK(a_last_flag, clk, rst_n, !out_empty |-> (out_last_texel == (out_texel_number == 4'd15)), "bad last flag")

  // Unsupported blocks give black transparent texels
  `ASSERT_CLK(a_unsup_zero, clk, rst_n, (!out_empty && out_status) |-> (out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0 && out_alpha_out == 8'd0), "unsupported texel not zero")

endmodule

bind bc7_block_decoder_unit bc7bd_checker u_checker (.*);
